@@ hdl/k_way_merge_selector_macros.svh @@
// Assertion macros shared by the merge selector RTL.
`ifndef K_WAY_MERGE_SELECTOR_MACROS_SVH
`define K_WAY_MERGE_SELECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kwm_pkg.sv @@
`default_nettype none

package kwm_pkg;

    localparam int VALUE_W = 32;
    localparam int RUN_IDX_W = 3;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 3;
    localparam int NUM_RUNS_W = 4;
    localparam logic [NUM_RUNS_W-1:0] NUM_RUNS_RESET = 4'd8;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_TAKEN = 3'd1,
        ST_DONE = 3'd2,
        ST_EMPTY = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_APPEND = 2'd1,
        OP_CLOSE = 2'd2,
        OP_TAKE = 2'd3
    } op_t;

    typedef struct packed {
        op_t op;
        logic [RUN_IDX_W-1:0] run;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t status;
        logic signed [VALUE_W-1:0] value;
        logic [RUN_IDX_W-1:0] source;
        logic refill;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/k_way_merge_selector.sv @@
`default_nettype none

// K-way merge selector: requests enter a two-entry queue (push/full) and are
// carried out one at a time; each result leaves through a one-entry result
// register (empty/pop). Append, close and unused kinds are handled in the
// execution stage once they leave the queue. A take scans the active runs one
// per cycle through the single read port of the element store and one signed
// comparator; it ends early at the first open run that has no data. No reset
// pass is needed: the store is only read at entries that have been written.

module k_way_merge_selector import kwm_pkg::*; #(
    parameter int MAX_RUNS = 8,
    parameter int BUF_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [KIND_W-1:0]          kind,
    input  logic [RUN_IDX_W-1:0]       run_index,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       empty,
    input  logic                       pop,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  taken_value,
    output logic [RUN_IDX_W-1:0]       source_run,
    output logic                       refill_request,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [NUM_RUNS_W-1:0]      num_runs
);

    localparam int RUN_W = $clog2(MAX_RUNS);
    localparam int NR_W = $clog2(MAX_RUNS + 1);

    logic [NUM_RUNS_W-1:0] num_runs_reg;
    logic [NR_W-1:0] n_active;
    logic [RUN_W-1:0] last_run;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic out_valid;
    result_t out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_runs_reg <= NUM_RUNS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_runs_reg <= num_runs;
        end
    end

    // A run count of zero acts as one; counts above the build limit are capped.
    always_comb
    begin
        if (num_runs_reg == '0)
        begin
            n_active = NR_W'(1);
        end
        else if (int'(num_runs_reg) > MAX_RUNS)
        begin
            n_active = NR_W'(MAX_RUNS);
        end
        else
        begin
            n_active = NR_W'(num_runs_reg);
        end
        last_run = RUN_W'(n_active - 1'b1);
    end

    kwm_front #(
        .MAX_RUNS(MAX_RUNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .kind     (kind),
        .run_index(run_index),
        .value    (value),
        .n_active (n_active),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop)
    );

    kwm_back #(
        .MAX_RUNS (MAX_RUNS),
        .BUF_DEPTH(BUF_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .last_run (last_run),
        .pop      (pop),
        .out_valid(out_valid),
        .out_res  (out_res)
    );

    assign empty = !out_valid;
    assign status = out_res.status;
    assign taken_value = out_res.value;
    assign source_run = out_res.source;
    assign refill_request = out_res.refill;

endmodule

`default_nettype wire

@@ hdl/kwm_ram.sv @@
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/kwm_front.sv @@
`default_nettype none

module kwm_front import kwm_pkg::*; #(
    parameter int MAX_RUNS = 8,
    localparam int NR_W = $clog2(MAX_RUNS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [KIND_W-1:0]           kind,
    input  logic [RUN_IDX_W-1:0]        run_index,
    input  logic signed [VALUE_W-1:0]   value,
    input  logic [NR_W-1:0]             n_active,
    output logic                        cmd_valid,
    output cmd_t                        cmd,
    input  logic                        cmd_pop
);

    cmd_t q_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0] count_reg, count_next;
    cmd_t in_cmd;
    logic push_ok;
    logic run_active;

    // An append or close to a run outside the active range becomes a no-op.
    always_comb
    begin
        run_active = int'(run_index) < int'(n_active);
        in_cmd.run = run_index;
        in_cmd.value = value;
        unique case (kind)
            KIND_APPEND: in_cmd.op = run_active ? OP_APPEND : OP_NOP;
            KIND_CLOSE:  in_cmd.op = run_active ? OP_CLOSE : OP_NOP;
            KIND_TAKE:   in_cmd.op = OP_TAKE;
            default:     in_cmd.op = OP_NOP;
        endcase
    end

    assign full = (count_reg == FQ_CNT_W'(FQ_DEPTH));
    assign push_ok = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push_ok, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/kwm_back.sv @@
`default_nettype none
`include "k_way_merge_selector_macros.svh"

module kwm_back import kwm_pkg::*; #(
    parameter int MAX_RUNS = 8,
    parameter int BUF_DEPTH = 16,
    localparam int RUN_W = $clog2(MAX_RUNS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    input  logic [RUN_W-1:0] last_run,
    input  logic             pop,
    output logic             out_valid,
    output result_t          out_res
);

    localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int STORE_DEPTH = MAX_RUNS * BUF_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] rp_reg [MAX_RUNS];
    logic [CNT_W-1:0] fill_reg [MAX_RUNS];
    logic closed_reg [MAX_RUNS];

    logic [RUN_W-1:0] idx_reg, idx_next;
    logic pend_valid_reg, pend_valid_next;
    logic [RUN_W-1:0] pend_run_reg, pend_run_next;
    logic found_reg, found_next;
    logic [RUN_W-1:0] best_run_reg, best_run_next;
    logic signed [VALUE_W-1:0] best_val_reg, best_val_next;
    logic out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;

    logic [RUN_W-1:0] cmd_run;
    logic [RUN_W-1:0] sel_run;
    logic [PTR_W-1:0] sel_rp;
    logic [CNT_W-1:0] sel_fill;
    logic sel_closed;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail_slot;
    logic [PTR_W-1:0] rp_inc;
    logic [ADDR_W-1:0] run_base;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] tail_addr;

    logic ram_we;
    logic [VALUE_W-1:0] ram_rdata;
    logic signed [VALUE_W-1:0] head_val;

    logic rp_we;
    logic [PTR_W-1:0] rp_wdata;
    logic fill_we;
    logic [CNT_W-1:0] fill_wdata;
    logic closed_set;

    assign cmd_run = RUN_W'(cmd.run);
    assign head_val = $signed(ram_rdata);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  sel_run = cmd_run;
            S_SCAN:  sel_run = idx_reg;
            default: sel_run = best_run_reg;
        endcase
    end

    assign sel_rp = rp_reg[sel_run];
    assign sel_fill = fill_reg[sel_run];
    assign sel_closed = closed_reg[sel_run];

    // Each run owns a contiguous slice of the store used as a circular buffer.
    always_comb
    begin
        tail_sum = SUM_W'(sel_rp) + SUM_W'(sel_fill);
        if (tail_sum >= SUM_W'(BUF_DEPTH))
        begin
            tail_slot = PTR_W'(tail_sum - SUM_W'(BUF_DEPTH));
        end
        else
        begin
            tail_slot = PTR_W'(tail_sum);
        end
        rp_inc = (sel_rp == PTR_W'(BUF_DEPTH - 1)) ? '0 : sel_rp + 1'b1;
        run_base = ADDR_W'(sel_run) * ADDR_W'(BUF_DEPTH);
        head_addr = run_base + ADDR_W'(sel_rp);
        tail_addr = run_base + ADDR_W'(tail_slot);
    end

    kwm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_addr),
        .wdata(cmd.value),
        .raddr(head_addr),
        .rdata(ram_rdata)
    );

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        pend_valid_next = 1'b0;
        pend_run_next = pend_run_reg;
        found_next = found_reg;
        best_run_next = best_run_reg;
        best_val_next = best_val_reg;
        out_valid_next = out_valid_reg && !pop;
        out_res_next = out_res_reg;
        ram_we = 1'b0;
        rp_we = 1'b0;
        rp_wdata = rp_inc;
        fill_we = 1'b0;
        fill_wdata = sel_fill + 1'b1;
        closed_set = 1'b0;

        // The head read issued in the previous scan cycle arrives now.
        if (pend_valid_reg && (!found_reg || head_val < best_val_reg))
        begin
            found_next = 1'b1;
            best_run_next = pend_run_reg;
            best_val_next = head_val;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    out_res_next.status = ST_ACCEPTED;
                    out_res_next.value = '0;
                    out_res_next.source = '0;
                    out_res_next.refill = 1'b0;
                    unique case (cmd.op)
                        OP_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (sel_fill == CNT_W'(BUF_DEPTH))
                            begin
                                out_res_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                fill_we = 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            out_valid_next = 1'b1;
                            closed_set = 1'b1;
                        end
                        OP_TAKE:
                        begin
                            state_next = S_SCAN;
                            idx_next = '0;
                            found_next = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (sel_fill == '0 && !sel_closed)
                begin
                    out_valid_next = 1'b1;
                    out_res_next.status = ST_EMPTY;
                    out_res_next.value = '0;
                    out_res_next.source = RUN_IDX_W'(idx_reg);
                    out_res_next.refill = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    pend_valid_next = (sel_fill != '0);
                    pend_run_next = idx_reg;
                    if (idx_reg == last_run)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                out_valid_next = 1'b1;
                out_res_next.value = '0;
                out_res_next.source = '0;
                out_res_next.refill = 1'b0;
                if (!found_reg)
                begin
                    out_res_next.status = ST_DONE;
                end
                else
                begin
                    out_res_next.status = ST_TAKEN;
                    out_res_next.value = best_val_reg;
                    out_res_next.source = RUN_IDX_W'(best_run_reg);
                    out_res_next.refill = (sel_fill == CNT_W'(1)) && !sel_closed;
                    rp_we = 1'b1;
                    fill_we = 1'b1;
                    fill_wdata = sel_fill - 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RUNS; i++)
            begin
                rp_reg[i] <= '0;
                fill_reg[i] <= '0;
                closed_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rp_we)
            begin
                rp_reg[sel_run] <= rp_wdata;
            end
            if (fill_we)
            begin
                fill_reg[sel_run] <= fill_wdata;
            end
            if (closed_set)
            begin
                closed_reg[sel_run] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            pend_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pend_valid_reg <= pend_valid_next;
            found_reg <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_run_reg <= pend_run_next;
        best_run_reg <= best_run_next;
        best_val_reg <= best_val_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res = out_res_reg;

    `KWM_ASSERT_SAME(a_busy_out_free, clk, rst_n, state_reg != S_IDLE, !out_valid_reg, "result register occupied during a take")
    `KWM_ASSERT_SAME(a_pend_after_scan, clk, rst_n, pend_valid_reg, $past(state_reg) == S_SCAN, "head read outside a scan")
    `KWM_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, sel_fill <= CNT_W'(BUF_DEPTH), "run buffer count out of range")
    `KWM_ASSERT_NEXT(a_finish_result, clk, rst_n, state_reg == S_FINISH, out_valid_reg && (state_reg == S_IDLE), "take finished without a result")

endmodule

`default_nettype wire

@@ tb/sv/merge_order_checker.sv @@
module merge_order_checker import kwm_pkg::*; #(
    parameter int RUNS = 8,
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      full,
    input  logic [KIND_W-1:0]         kind,
    input  logic [RUN_IDX_W-1:0]      run_index,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [STATUS_W-1:0]       status,
    input  logic signed [VALUE_W-1:0] taken_value,
    input  logic [RUN_IDX_W-1:0]      source_run,
    input  logic                      refill_request,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [NUM_RUNS_W-1:0]     num_runs,
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_checked,
    output int                        values_taken
);

    localparam int PRINT_CAP = 100;

    logic signed [VALUE_W-1:0] run_data [RUNS][DEPTH];
    logic [3:0]                head_ptr [RUNS];
    logic [4:0]                fill_cnt [RUNS];
    logic                      closed [RUNS];
    logic [NUM_RUNS_W-1:0]     runs_reg;
    result_t                   merge_results [$];
    result_t                   want;

    function automatic result_t merge_next_result(
        input logic [KIND_W-1:0]         k,
        input logic [RUN_IDX_W-1:0]      r,
        input logic signed [VALUE_W-1:0] v
    );
        result_t                   res;
        int                        live;
        int                        i;
        int                        best;
        logic signed [VALUE_W-1:0] head;
        logic signed [VALUE_W-1:0] best_head;
        res = '0;
        res.status = ST_ACCEPTED;
        best = -1;
        best_head = '0;
        live = (runs_reg == 0) ? 1 : (runs_reg > RUNS) ? RUNS : int'(runs_reg);
        case (k)
            KIND_APPEND:
            begin
                if (r < live)
                begin
                    if (fill_cnt[r] >= DEPTH)
                        res.status = ST_OVERFLOW;
                    else
                    begin
                        run_data[r][4'(head_ptr[r] + fill_cnt[r])] = v;
                        fill_cnt[r] = fill_cnt[r] + 5'd1;
                    end
                end
            end
            KIND_CLOSE:
            begin
                if (r < live)
                    closed[r] = 1'b1;
            end
            KIND_TAKE:
            begin
                // An open run without data may still hold the smallest value.
                for (i = 0; i < live; i++)
                begin
                    if (fill_cnt[i] == 0 && !closed[i])
                    begin
                        res.status = ST_EMPTY;
                        res.source = 3'(i);
                        return res;
                    end
                end
                for (i = 0; i < live; i++)
                begin
                    if (fill_cnt[i] != 0)
                    begin
                        head = run_data[i][head_ptr[i]];
                        if (best < 0 || head < best_head)
                        begin
                            best = i;
                            best_head = head;
                        end
                    end
                end
                if (best < 0)
                    res.status = ST_DONE;
                else
                begin
                    head_ptr[best] = head_ptr[best] + 4'd1;
                    fill_cnt[best] = fill_cnt[best] - 5'd1;
                    res.status = ST_TAKEN;
                    res.value = best_head;
                    res.source = 3'(best);
                    res.refill = (fill_cnt[best] == 0) && !closed[best];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: result %0d: %s", $time, results_checked, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RUNS; i++)
            begin
                head_ptr[i] = '0;
                fill_cnt[i] = '0;
                closed[i] = 1'b0;
            end
            runs_reg = NUM_RUNS_RESET;
            merge_results.delete();
            mismatches = 0;
            results_checked = 0;
            values_taken = 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (merge_results.size() == 0)
                    report_mismatch($sformatf("unexpected result, status %0d", status));
                else
                begin
                    want = merge_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, want.status));
                    if (taken_value !== want.value)
                        report_mismatch($sformatf("taken_value %0d, want %0d",
                                                  taken_value, want.value));
                    if (source_run !== want.source)
                        report_mismatch($sformatf("source_run %0d, want %0d",
                                                  source_run, want.source));
                    if (refill_request !== want.refill)
                        report_mismatch($sformatf("refill_request %0b, want %0b",
                                                  refill_request, want.refill));
                    if (want.status == ST_TAKEN)
                        values_taken++;
                end
                results_checked++;
            end
            if (push && !full)
                merge_results.push_back(merge_next_result(kind, run_index, value));
            if (cfg_valid && cfg_ready)
                runs_reg = num_runs;
            outstanding <= merge_results.size();
        end
    end

endmodule

@@ tb/sv/tb_k_way_merge_selector.sv @@
module tb_k_way_merge_selector import kwm_pkg::*;;

    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [31:0]        RUN_SETTINGS = 32'h8_9_5_F_0_8_1_3;
    localparam int                 PHASES = 8;
    localparam int                 PHASE_REQUESTS = 80;
    localparam int                 HOLD_CYCLES = 60;
    localparam int                 QUIET_LIMIT = 2000;
    localparam int                 END_SETTLE = 30;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [KIND_W-1:0]         kind;
    logic [RUN_IDX_W-1:0]      run_index;
    logic signed [VALUE_W-1:0] value;
    logic                      empty;
    logic                      pop;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] taken_value;
    logic [RUN_IDX_W-1:0]      source_run;
    logic                      refill_request;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [NUM_RUNS_W-1:0]     num_runs;

    int mismatches;
    int outstanding;
    int results_checked;
    int values_taken;
    int requests_sent;
    int send_idle_pct;
    int pop_stall_pct;
    int hold_left;
    int quiet_cycles;

    logic signed [VALUE_W-1:0] run_tail [8];

    k_way_merge_selector i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .run_index      (run_index),
        .value          (value),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .taken_value    (taken_value),
        .source_run     (source_run),
        .refill_request (refill_request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .num_runs       (num_runs)
    );

    merge_order_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .run_index       (run_index),
        .value           (value),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .taken_value     (taken_value),
        .source_run      (source_run),
        .refill_request  (refill_request),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .num_runs        (num_runs),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .values_taken    (values_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles.", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(
        input logic [KIND_W-1:0]    k,
        input logic [RUN_IDX_W-1:0] r,
        input logic [VALUE_W-1:0]   v
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        run_index <= r;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (k != KIND_UNUSED)
            requests_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_num_runs(input logic [NUM_RUNS_W-1:0] setting);
        cfg_valid <= 1'b1;
        num_runs <= setting;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] grow_run(input int idx, input bit narrow);
        run_tail[idx] = run_tail[idx] + (narrow ? $urandom_range(2) : $urandom_range(40000));
        return run_tail[idx];
    endfunction

    task automatic run_session(input int live);
        int idx;
        int cnt;
        int j;
        int total;
        bit narrow;
        narrow = ($urandom_range(1) == 0);
        total = 0;
        for (idx = 0; idx < live; idx++)
        begin
            run_tail[idx] = narrow ? $signed($urandom_range(8)) - 4 : $signed($urandom);
            cnt = ($urandom_range(9) == 0) ? $urandom_range(19, 14) : $urandom_range(5);
            for (j = 0; j < cnt; j++)
                send_request(KIND_APPEND, 3'(idx), grow_run(idx, narrow));
            total += cnt;
            if ($urandom_range(2) == 0)
                send_request(KIND_CLOSE, 3'(idx), $urandom);
        end
        for (j = 0; j < total + 2; j++)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    idx = $urandom_range(live - 1);
                    send_request(KIND_APPEND, 3'(idx), grow_run(idx, narrow));
                end
                2:
                    send_request(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom);
                default:
                    send_request(KIND_TAKE, 3'($urandom_range(7)), $urandom);
            endcase
        end
    endtask

    initial
    begin
        int p;
        int live;
        int phase_end;
        logic [NUM_RUNS_W-1:0] setting;
        rst_n = 1'b0;
        push = 1'b0;
        kind = KIND_APPEND;
        run_index = '0;
        value = '0;
        cfg_valid = 1'b0;
        num_runs = NUM_RUNS_RESET;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_left = 0;
        requests_sent = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_num_runs(4'd2);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_APPEND, 3'd0, VAL_MIN);
        send_request(KIND_TAKE, 3'd7, '1);
        send_request(KIND_APPEND, 3'd1, VAL_MIN);
        send_request(KIND_APPEND, 3'd1, VAL_MAX);
        send_request(KIND_APPEND, 3'd7, 32'h5a5a_a5a5);
        send_request(KIND_CLOSE, 3'd7, '0);
        send_request(KIND_UNUSED, 3'd5, '1);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_APPEND, 3'd0, '1);
        send_request(KIND_APPEND, 3'd0, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_CLOSE, 3'd0, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_CLOSE, 3'd1, '0);
        send_request(KIND_CLOSE, 3'd1, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_APPEND, 3'd0, 32'd7);
        send_request(KIND_TAKE, 3'd0, '0);
        send_request(KIND_TAKE, 3'd0, '0);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            setting = RUN_SETTINGS[4*p +: 4];
            write_num_runs(setting);
            live = (setting == 0) ? 1 : (setting > 8) ? 8 : int'(setting);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                    hold_left = HOLD_CYCLES;
                end
                1:
                begin
                    send_idle_pct = 60;
                    pop_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 60;
                end
                default:
                begin
                    send_idle_pct = 12;
                    pop_stall_pct = 12;
                end
            endcase
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end)
                run_session(live);
            drain();
        end

        repeat (END_SETTLE) @(posedge clk);
        $display("Sent %0d requests across nine num_runs writes, 0, 9 and 15 among them;",
                 requests_sent);
        $display("checked %0d results, %0d of them merged values, under four idle mixes.",
                 results_checked, values_taken);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
